// File: rtl/sn3_pkg.sv
// Shared constants, types and lookup tables for the 3D simplex noise pipeline.
// No dependencies; every other file imports this package.
package sn3_pkg;

    // Number formats
    localparam int COORD_WIDTH     = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_WIDTH       = 16;
    localparam int INT_FRAC        = 24;

    // Pipeline depth from start to done
    localparam int LATENCY = 12;

    // Skew sum and its floor division by three (split in two narrow halves)
    localparam int SUM_W    = COORD_WIDTH + 3;
    localparam int SPLIT    = 18;
    localparam int HI_W     = SUM_W - SPLIT;
    localparam int LO_W     = SPLIT + 2;
    localparam int HI_K     = HI_W + 1;
    localparam int LO_K     = LO_W + 1;
    localparam int HI_PW    = HI_W + HI_K;
    localparam int LO_PW    = LO_W + LO_K;
    localparam logic [HI_K-1:0] HI_M = HI_K'(((64'd1 << HI_K) + 64'd2) / 64'd3);
    localparam logic [LO_K-1:0] LO_M = LO_K'(((64'd1 << LO_K) + 64'd2) / 64'd3);
    localparam logic [SUM_W-1:0] SUM_BIAS = SUM_W'(64'd3 << (SUM_W - 2));
    localparam logic [SUM_W-1:0] S_BIAS   = SUM_W'(64'd1 << (SUM_W - 2));
    localparam int S_W = COORD_WIDTH + 2;

    // Base offsets and corner offsets, in units of 2^-F/6
    localparam int NB_W = COORD_FRAC_BITS + 5;
    localparam int N_W  = COORD_FRAC_BITS + 7;
    localparam int UP_SHIFT = INT_FRAC - COORD_FRAC_BITS - 1;
    localparam int W_W  = N_W + UP_SHIFT;
    localparam logic signed [N_W-1:0] STEP_SIX = N_W'(64'd6 << COORD_FRAC_BITS);
    localparam logic signed [N_W-1:0] UNIT_ONE = N_W'(64'd1 << COORD_FRAC_BITS);

    // Conversion to Q.INT_FRAC: biased unsigned value times reciprocal of three
    localparam int U_W    = INT_FRAC + 5;
    localparam int CONV_K = U_W + 1;
    localparam int PROD_W = U_W + CONV_K;
    localparam logic [CONV_K-1:0] CONV_M = CONV_K'(((64'd1 << CONV_K) + 64'd2) / 64'd3);
    localparam logic [W_W-1:0] CONV_BIAS = W_W'(64'd3 << (U_W - 2));
    localparam int Q_W = PROD_W - CONV_K;
    localparam logic [Q_W:0] CONV_OFS = (Q_W + 1)'(64'd1 << (U_W - 2));

    // Falloff widths
    localparam int O_W    = INT_FRAC + 3;
    localparam int SQ_W   = 2 * INT_FRAC + 3;
    localparam int SUMSQ_W = SQ_W + 1;
    localparam int R2_W   = SUMSQ_W - INT_FRAC;
    localparam int T_W    = INT_FRAC;
    localparam int T2_W   = INT_FRAC - 1;
    localparam int T4_W   = INT_FRAC - 3;
    localparam int DOT_W  = O_W + 2;
    localparam int TERM_W = T4_W + 1 + DOT_W;
    localparam int ACC_W  = TERM_W + 2;
    localparam int RES_SHIFT = 2 * INT_FRAC - 4 - OUT_WIDTH;
    localparam int RES_W  = ACC_W - RES_SHIFT;
    localparam logic [R2_W-1:0] T_HALF = R2_W'(64'd1 << (INT_FRAC - 1));

    // Item after skew and floor: wrapped cell, fraction bits, sum mod 3
    typedef struct packed {
        logic [2:0][7:0]                 cw;
        logic [2:0][COORD_FRAC_BITS-1:0] fa;
        logic [1:0]                      rem;
    } cell_t;

    // One corner after hashing: permutation output and scaled offsets
    typedef struct packed {
        logic [7:0]             h;
        logic [2:0][PROD_W-1:0] prod;
    } corner_t;

    localparam logic [7:0] PERM_TAB [0:255] = '{
        8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
        8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
        8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
        8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
        8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
        8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
        8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
        8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
        8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
        8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
        8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
        8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
        8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
        8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
        8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
        8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
        8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
        8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
        8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
        8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
        8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
        8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
    };

    // Edge gradients, components as -1, 0, +1
    localparam logic signed [1:0] GRAD_TAB [0:11][0:2] = '{
        '{2'sd1, 2'sd1, 2'sd0}, '{-2'sd1, 2'sd1, 2'sd0},
        '{2'sd1, -2'sd1, 2'sd0}, '{-2'sd1, -2'sd1, 2'sd0},
        '{2'sd1, 2'sd0, 2'sd1}, '{-2'sd1, 2'sd0, 2'sd1},
        '{2'sd1, 2'sd0, -2'sd1}, '{-2'sd1, 2'sd0, -2'sd1},
        '{2'sd0, 2'sd1, 2'sd1}, '{2'sd0, -2'sd1, 2'sd1},
        '{2'sd0, 2'sd1, -2'sd1}, '{2'sd0, -2'sd1, -2'sd1}
    };

    // Reduce a hash byte modulo 12 by reciprocal multiply
    function automatic logic [3:0] mod12(input logic [7:0] h);
        logic [15:0] p;
        logic [4:0]  q;
        p = 16'(h) * 16'd171;
        q = p[15:11];
        return 4'(h - 8'(q) * 8'd12);
    endfunction

    // Dot product of an edge gradient with one offset vector
    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [3:0]            gi,
        input logic signed [O_W-1:0] o0,
        input logic signed [O_W-1:0] o1,
        input logic signed [O_W-1:0] o2
    );
        logic signed [DOT_W-1:0] acc;
        logic signed [O_W-1:0]   ov [0:2];
        acc = '0;
        ov[0] = o0;
        ov[1] = o1;
        ov[2] = o2;
        for (int a = 0; a < 3; a++)
        begin
            if (GRAD_TAB[gi][a] == 2'sd1)
                acc = acc + DOT_W'(ov[a]);
            else if (GRAD_TAB[gi][a] == -2'sd1)
                acc = acc - DOT_W'(ov[a]);
        end
        return acc;
    endfunction

endpackage

// File: rtl/sn3_skew.sv
// Skew and floor stages: sum divided by three, then cell index and fraction.
// Depends on sn3_pkg.
module sn3_skew
    import sn3_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          out_valid,
    output cell_t                         out_cell
);

    logic v1_reg, v2_reg, v3_reg;

    logic signed [COORD_WIDTH-1:0] x1_reg [0:2];
    logic signed [COORD_WIDTH-1:0] x2_reg [0:2];
    logic [HI_W-1:0] qh_reg, qh_next;
    logic [1:0]      rh_reg, rh_next;
    logic [SPLIT-1:0] ul_reg;
    logic signed [S_W-1:0] s_reg, s_next;
    logic [1:0]      rem_reg, rem_next;
    cell_t           cell_reg, cell_next;

    logic signed [SUM_W-1:0] sum_w;
    logic [SUM_W-1:0]        u_w;
    logic [HI_W-1:0]         uh;
    logic [HI_PW-1:0]        hi_prod;
    logic [LO_W-1:0]         v_w;
    logic [LO_PW-1:0]        lo_prod;
    logic [LO_W-1:0]         ql;
    logic [SUM_W-1:0]        q_all;

    // Stage 1: biased sum, high half divided by three
    always_comb
    begin
        sum_w   = SUM_W'(coord_x) + SUM_W'(coord_y) + SUM_W'(coord_z);
        u_w     = unsigned'(sum_w) + SUM_BIAS;
        uh      = u_w[SUM_W-1:SPLIT];
        hi_prod = HI_PW'(uh) * HI_PW'(HI_M);
        qh_next = HI_W'(hi_prod[HI_PW-1:HI_K]);
        rh_next = 2'(uh - qh_next - (qh_next << 1));
    end

    // Stage 2: remainder joins low half, finish floor(sum/3)
    always_comb
    begin
        v_w      = {rh_reg, ul_reg};
        lo_prod  = LO_PW'(v_w) * LO_PW'(LO_M);
        ql       = LO_W'(lo_prod[LO_PW-1:LO_K]);
        rem_next = 2'(v_w - ql - (ql << 1));
        q_all    = {qh_reg, {SPLIT{1'b0}}} + SUM_W'(ql);
        s_next   = signed'(S_W'(q_all - S_BIAS));
    end

    // Stage 3: skewed coordinate, wrapped cell and fraction
    always_comb
    begin
        logic signed [S_W-1:0] a_w;
        cell_next.rem = rem_reg;
        for (int k = 0; k < 3; k++)
        begin
            a_w = S_W'(x2_reg[k]) + s_reg;
            cell_next.cw[k] = a_w[COORD_FRAC_BITS+7:COORD_FRAC_BITS];
            cell_next.fa[k] = a_w[COORD_FRAC_BITS-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Hold payload per stage
    always_ff @(posedge clk)
    begin
        x1_reg[0] <= coord_x;
        x1_reg[1] <= coord_y;
        x1_reg[2] <= coord_z;
        qh_reg    <= qh_next;
        rh_reg    <= rh_next;
        ul_reg    <= u_w[SPLIT-1:0];
        x2_reg    <= x1_reg;
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        cell_reg  <= cell_next;
    end

    assign out_valid = v3_reg;
    assign out_cell  = cell_reg;

endmodule

// File: rtl/sn3_corners.sv
// Corner stages: base offsets, simplex ordering, three-step permutation hash
// and scaled corner offsets for all four corners. Depends on sn3_pkg.
module sn3_corners
    import sn3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cell_t              in_cell,
    output logic               out_valid,
    output corner_t [3:0]      out_corner
);

    logic v4_reg, v5_reg, v6_reg;

    logic signed [NB_W-1:0] nb_reg [0:2];
    logic signed [NB_W-1:0] nb_next [0:2];
    logic [2:0] st1_reg, st1_next, st2_reg, st2_next;
    logic [7:0] pz0_reg, pz1_reg;
    logic [7:0] cwx4_reg, cwy4_reg, cwx5_reg;

    logic [7:0]       h2_reg   [0:3];
    logic [7:0]       h2_next  [0:3];
    logic [2:0]       st5_reg  [0:3];
    logic [2:0]       st5_next [0:3];
    logic [U_W-1:0]   u_reg    [0:3][0:2];
    logic [U_W-1:0]   u_next   [0:3][0:2];
    corner_t [3:0]    corner_reg, corner_next;

    // Stage 4: exact base offsets and corner order
    always_comb
    begin
        logic [COORD_FRAC_BITS+1:0] fsum;
        fsum = (COORD_FRAC_BITS+2)'(in_cell.fa[0]) + (COORD_FRAC_BITS+2)'(in_cell.fa[1])
             + (COORD_FRAC_BITS+2)'(in_cell.fa[2]);
        for (int a = 0; a < 3; a++)
        begin
            nb_next[a] = signed'(NB_W'({in_cell.fa[a], 2'b00}) + NB_W'({in_cell.fa[a], 1'b0})
                       + NB_W'(in_cell.rem) - NB_W'(fsum));
        end
        if (nb_next[0] >= nb_next[1])
        begin
            if (nb_next[1] >= nb_next[2])
            begin
                st1_next = 3'b001;
                st2_next = 3'b011;
            end
            else if (nb_next[0] >= nb_next[2])
            begin
                st1_next = 3'b001;
                st2_next = 3'b101;
            end
            else
            begin
                st1_next = 3'b100;
                st2_next = 3'b101;
            end
        end
        else
        begin
            if (nb_next[1] < nb_next[2])
            begin
                st1_next = 3'b100;
                st2_next = 3'b110;
            end
            else if (nb_next[0] < nb_next[2])
            begin
                st1_next = 3'b010;
                st2_next = 3'b110;
            end
            else
            begin
                st1_next = 3'b010;
                st2_next = 3'b011;
            end
        end
    end

    // Stage 5: second hash lookup and biased corner offsets
    always_comb
    begin
        logic [2:0]             st;
        logic [7:0]             h1;
        logic signed [N_W-1:0]  n;
        logic signed [W_W-1:0]  w;
        for (int c = 0; c < 4; c++)
        begin
            case (c)
                0: st = 3'b000;
                1: st = st1_reg;
                2: st = st2_reg;
                default: st = 3'b111;
            endcase
            h1 = st[2] ? pz1_reg : pz0_reg;
            h2_next[c]  = PERM_TAB[8'(cwy4_reg + 8'(st[1]) + h1)];
            st5_next[c] = st;
            for (int a = 0; a < 3; a++)
            begin
                n = N_W'(nb_reg[a]) - (st[a] ? STEP_SIX : '0) + N_W'(UNIT_ONE * N_W'(c));
                w = W_W'(n) <<< UP_SHIFT;
                u_next[c][a] = U_W'(unsigned'(w) + CONV_BIAS);
            end
        end
    end

    // Stage 6: last hash lookup, reciprocal multiply for the offsets
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            corner_next[c].h = PERM_TAB[8'(cwx5_reg + 8'(st5_reg[c][0]) + h2_reg[c])];
            for (int a = 0; a < 3; a++)
                corner_next[c].prod[a] = PROD_W'(u_reg[c][a]) * PROD_W'(CONV_M);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Hold payload per stage
    always_ff @(posedge clk)
    begin
        nb_reg     <= nb_next;
        st1_reg    <= st1_next;
        st2_reg    <= st2_next;
        pz0_reg    <= PERM_TAB[in_cell.cw[2]];
        pz1_reg    <= PERM_TAB[8'(in_cell.cw[2] + 8'd1)];
        cwx4_reg   <= in_cell.cw[0];
        cwy4_reg   <= in_cell.cw[1];
        h2_reg     <= h2_next;
        st5_reg    <= st5_next;
        u_reg      <= u_next;
        cwx5_reg   <= cwx4_reg;
        corner_reg <= corner_next;
    end

    assign out_valid  = v6_reg;
    assign out_corner = corner_reg;

endmodule

// File: rtl/sn3_falloff.sv
// Falloff stages for one corner: offsets, squared radius, (0.5-r2)^4 and the
// gradient term. Depends on sn3_pkg.
module sn3_falloff
    import sn3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  corner_t                  in_corner,
    output logic                     out_valid,
    output logic signed [TERM_W-1:0] term
);

    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;

    logic [SQ_W-1:0]         sq_reg  [0:2];
    logic [SQ_W-1:0]         sq_next [0:2];
    logic signed [DOT_W-1:0] dot7_reg, dot_next, dot8_reg, dot9_reg, dot10_reg;
    logic [T_W-1:0]          t_reg, t_next;
    logic                    keep8_reg, keep_next, keep9_reg, keep10_reg;
    logic [T2_W-1:0]         t2_reg;
    logic [T4_W-1:0]         t4_reg;
    logic signed [TERM_W-1:0] term_reg, term_next;

    logic signed [O_W-1:0]   o_w [0:2];
    logic [SUMSQ_W-1:0]      sumsq;
    logic [R2_W-1:0]         r2;
    logic [2*T_W-1:0]        tt;
    logic [2*T2_W-1:0]       tt2;

    // Stage 7: offsets in Q.INT_FRAC, squares and gradient dot product
    always_comb
    begin
        logic [Q_W-1:0]            q;
        logic signed [2*O_W-1:0]   p;
        for (int a = 0; a < 3; a++)
        begin
            q = in_corner.prod[a][PROD_W-1:CONV_K];
            o_w[a] = signed'(O_W'({1'b0, q} - CONV_OFS));
            p = o_w[a] * o_w[a];
            sq_next[a] = SQ_W'(unsigned'(p));
        end
        dot_next = grad_dot(mod12(in_corner.h), o_w[0], o_w[1], o_w[2]);
    end

    // Stage 8: radius and falloff base, drop the corner when negative
    always_comb
    begin
        sumsq     = SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[1]) + SUMSQ_W'(sq_reg[2]);
        r2        = sumsq[SUMSQ_W-1:INT_FRAC];
        keep_next = (r2 <= T_HALF);
        t_next    = T_W'(T_HALF - r2);
    end

    // Stage 9 and 10: square twice
    assign tt  = (2*T_W)'(t_reg) * (2*T_W)'(t_reg);
    assign tt2 = (2*T2_W)'(t2_reg) * (2*T2_W)'(t2_reg);

    // Stage 11: weighted gradient term
    always_comb
    begin
        if (keep10_reg)
            term_next = TERM_W'(signed'({1'b0, t4_reg})) * TERM_W'(dot10_reg);
        else
            term_next = '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else
        begin
            v7_reg  <= in_valid;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    // Hold payload per stage
    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        dot7_reg   <= dot_next;
        t_reg      <= t_next;
        keep8_reg  <= keep_next;
        dot8_reg   <= dot7_reg;
        t2_reg     <= T2_W'(tt[2*T_W-1:INT_FRAC]);
        keep9_reg  <= keep8_reg;
        dot9_reg   <= dot8_reg;
        t4_reg     <= T4_W'(tt2[2*T2_W-1:INT_FRAC]);
        keep10_reg <= keep9_reg;
        dot10_reg  <= dot9_reg;
        term_reg   <= term_next;
    end

    assign out_valid = v11_reg;
    assign term      = term_reg;

endmodule

// File: rtl/simplex_noise_3d.sv
// 3D simplex noise: one point per clock, never busy.
// An item taken on start appears on noise_value with done once it has passed
// the whole pipeline; busy stays low, so a new point may be given in every
// cycle. The pipeline holds three skew stages (the divide by three is done in
// two halves), three hash stages (three chained permutation lookups),
// five falloff stages (squares, radius, two squarings and the weighted term)
// and the output sum and saturate.
// The result strobe cannot be held off. Depends on sn3_pkg, sn3_skew,
// sn3_corners and sn3_falloff.
module simplex_noise_3d
    import sn3_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          done,
    output logic signed [OUT_WIDTH-1:0]   noise_value
);

    logic          skew_valid;
    cell_t         skew_cell;
    logic          crn_valid;
    corner_t [3:0] crn_item;
    logic [3:0]    fall_valid;
    logic signed [TERM_W-1:0] fall_term [0:3];

    logic                        done_reg;
    logic signed [OUT_WIDTH-1:0] noise_reg, noise_next;

    assign busy = 1'b0;

    sn3_skew u_skew (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (skew_valid),
        .out_cell  (skew_cell)
    );

    sn3_corners u_corners (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (skew_valid),
        .in_cell    (skew_cell),
        .out_valid  (crn_valid),
        .out_corner (crn_item)
    );

    for (genvar c = 0; c < 4; c++)
    begin : g_fall
        sn3_falloff u_fall (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (crn_valid),
            .in_corner (crn_item[c]),
            .out_valid (fall_valid[c]),
            .term      (fall_term[c])
        );
    end

    // Sum the four corners, scale and saturate
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic signed [RES_W-1:0] res;
        acc = ACC_W'(fall_term[0]) + ACC_W'(fall_term[1])
            + ACC_W'(fall_term[2]) + ACC_W'(fall_term[3]);
        res = RES_W'(acc >>> RES_SHIFT);
        if (res > RES_W'(signed'({1'b0, {(OUT_WIDTH-1){1'b1}}})))
            noise_next = {1'b0, {(OUT_WIDTH-1){1'b1}}};
        else if (res < RES_W'(signed'({1'b1, {(OUT_WIDTH-1){1'b0}}})))
            noise_next = {1'b1, {(OUT_WIDTH-1){1'b0}}};
        else
            noise_next = OUT_WIDTH'(res);
    end

    // Strobe the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= &fall_valid;
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
    end

    assign done        = done_reg;
    assign noise_value = noise_reg;

endmodule

// File: rtl/sn3_checker.sv
// Port-level checks for simplex_noise_3d and the bind that attaches them.
// Depends on sn3_pkg and simplex_noise_3d.
module sn3_checker
    import sn3_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] coord_x,
    input logic signed [COORD_WIDTH-1:0] coord_y,
    input logic signed [COORD_WIDTH-1:0] coord_z,
    input logic                          done,
    input logic signed [OUT_WIDTH-1:0]   noise_value
);

    // Accepted item always yields its result after the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item accepted without result after pipeline depth");

    // No result without an item accepted one pipeline depth earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without an accepted item");

    // Block never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Origin of the lattice gives zero noise
    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && coord_x == '0 && coord_y == '0 && coord_z == '0)
            |-> ##LATENCY (noise_value == '0))
        else $error("nonzero noise at the origin");

endmodule

bind simplex_noise_3d sn3_checker u_sn3_checker (.*);

// File: bench/tb_simplex_noise_3d.sv
// Self-checking testbench for the 3D simplex noise pipeline.
// Depends on sn3_pkg for widths; holds its own noise predictor and tables.
module tb_simplex_noise_3d;
    import sn3_pkg::COORD_WIDTH;
    import sn3_pkg::OUT_WIDTH;
    import sn3_pkg::LATENCY;

    localparam int FRAC = 16;
    localparam int QF = 24;
    localparam int NUM_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic done;
    logic signed [OUT_WIDTH-1:0] noise_value;

    simplex_noise_3d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .done(done), .noise_value(noise_value)
    );

    byte unsigned lattice_perm [0:255] = '{
        151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
        8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
        35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
        134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
        55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
        18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
        250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
        189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
        172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
        228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
        107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
        138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
    };
    int edge_grad [0:11][0:2] = '{
        '{1,1,0}, '{-1,1,0}, '{1,-1,0}, '{-1,-1,0},
        '{1,0,1}, '{-1,0,1}, '{1,0,-1}, '{-1,0,-1},
        '{0,1,1}, '{0,-1,1}, '{0,1,-1}, '{0,-1,-1}
    };

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        bit has_value;
        logic signed [OUT_WIDTH-1:0] value;
    } point_row_t;

    logic signed [OUT_WIDTH-1:0] noise_queue [$];
    int mismatches;
    longint cycles;

    // Floor divide toward minus infinity
    function automatic longint floor_div(longint v, longint d);
        longint q;
        q = v / d;
        if ((v % d) != 0 && v < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint to_fixed(longint n);
        longint lim;
        lim = longint'(24) << FRAC;
        if (n > lim) n = lim;
        if (n < -lim) n = -lim;
        return floor_div(n * (longint'(1) << (QF - FRAC)), 6);
    endfunction

    function automatic int lattice_hash(int c [3], int st [3]);
        int h;
        h = lattice_perm[(c[2] + st[2]) & 255];
        h = lattice_perm[(c[1] + st[1] + h) & 255];
        h = lattice_perm[(c[0] + st[0] + h) & 255];
        return h % 12;
    endfunction

    function automatic longint corner_term(longint nb [3], int st [3], int m, int gi);
        longint o, r2, t, t2, t4, dot;
        r2 = 0;
        dot = 0;
        for (int a = 0; a < 3; a++)
        begin
            o = to_fixed(nb[a] - 6 * (longint'(st[a]) << FRAC) + (longint'(m) << FRAC));
            r2 += o * o;
            dot += edge_grad[gi][a] * o;
        end
        r2 = r2 >>> QF;
        t = (longint'(1) << (QF - 1)) - r2;
        if (t < 0)
            return 0;
        t2 = (t * t) >>> QF;
        t4 = (t2 * t2) >>> QF;
        return t4 * dot;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] predict_noise(
        logic signed [COORD_WIDTH-1:0] x, logic signed [COORD_WIDTH-1:0] y,
        logic signed [COORD_WIDTH-1:0] z);
        longint p [3];
        longint lat_base [3];
        longint nb [3];
        longint s, csum, acc, res, hi;
        int cw [3];
        int st0 [3];
        int st1 [3];
        int st2 [3];
        int st3 [3];
        p[0] = x;
        p[1] = y;
        p[2] = z;
        st0 = '{0, 0, 0};
        st1 = '{0, 0, 0};
        st2 = '{0, 0, 0};
        st3 = '{1, 1, 1};
        csum = 0;
        s = floor_div(p[0] + p[1] + p[2], 3);
        for (int a = 0; a < 3; a++)
        begin
            lat_base[a] = ((p[a] + s) >>> FRAC) <<< FRAC;
            csum += lat_base[a];
            cw[a] = int'(((p[a] + s) >>> FRAC) & 255);
        end
        for (int a = 0; a < 3; a++)
            nb[a] = 6 * (p[a] - lat_base[a]) + csum;
        // Pick the middle two corners from the offset ordering
        if (nb[0] >= nb[1])
        begin
            if (nb[1] >= nb[2])      begin st1[0] = 1; st2[0] = 1; st2[1] = 1; end
            else if (nb[0] >= nb[2]) begin st1[0] = 1; st2[0] = 1; st2[2] = 1; end
            else                     begin st1[2] = 1; st2[0] = 1; st2[2] = 1; end
        end
        else
        begin
            if (nb[1] < nb[2])       begin st1[2] = 1; st2[1] = 1; st2[2] = 1; end
            else if (nb[0] < nb[2])  begin st1[1] = 1; st2[1] = 1; st2[2] = 1; end
            else                     begin st1[1] = 1; st2[0] = 1; st2[1] = 1; end
        end
        acc = corner_term(nb, st0, 0, lattice_hash(cw, st0))
            + corner_term(nb, st1, 1, lattice_hash(cw, st1))
            + corner_term(nb, st2, 2, lattice_hash(cw, st2))
            + corner_term(nb, st3, 3, lattice_hash(cw, st3));
        res = acc >>> (2 * QF - 4 - OUT_WIDTH);
        hi = (longint'(1) << (OUT_WIDTH - 1)) - 1;
        if (res > hi) res = hi;
        if (res < -hi - 1) res = -hi - 1;
        return OUT_WIDTH'(res);
    endfunction

    // Clock and cycle limit
    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (noise_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", noise_value);
            end
            else
            begin
                if (noise_value !== noise_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value mismatch: expected %0d, got %0d",
                                 noise_queue[0], noise_value);
                end
                void'(noise_queue.pop_front());
            end
        end
    end

    // Offer one point and hold it until accepted
    task automatic send_point(logic signed [COORD_WIDTH-1:0] x,
                              logic signed [COORD_WIDTH-1:0] y,
                              logic signed [COORD_WIDTH-1:0] z);
        start <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        do
            @(posedge clk);
        while (busy);
        noise_queue.push_back(predict_noise(x, y, z));
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return 32'($urandom_range(0, 8)) << ($urandom_range(0, 15) + 16);
            default: return 32'($signed($urandom_range(0, 32'h03ff_ffff)) - 32'sh0200_0000);
        endcase
    endfunction

    point_row_t directed [] = '{
        '{32'sd0, 32'sd0, 32'sd0, 1'b1, 16'sd0},
        '{32'sh0001_0000, 32'sd0, 32'sd0, 1'b0, 16'sd0},
        '{32'sh0000_8000, 32'sh0000_4000, 32'sh0000_2000, 1'b0, 16'sd0},
        '{32'sh0000_2000, 32'sh0000_4000, 32'sh0000_8000, 1'b0, 16'sd0},
        '{32'sh0000_4000, 32'sh0000_8000, 32'sh0000_2000, 1'b0, 16'sd0},
        '{32'sh0000_4000, 32'sh0000_2000, 32'sh0000_8000, 1'b0, 16'sd0},
        '{32'sh0000_8000, 32'sh0000_2000, 32'sh0000_4000, 1'b0, 16'sd0},
        '{32'sh0000_2000, 32'sh0000_8000, 32'sh0000_4000, 1'b0, 16'sd0},
        '{32'sh0000_5555, 32'sh0000_5555, 32'sh0000_5555, 1'b0, 16'sd0},
        '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 16'sd0},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 16'sd0},
        '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 1'b0, 16'sd0},
        '{32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff, 1'b0, 16'sd0},
        '{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 1'b0, 16'sd0},
        '{32'sh0100_3456, 32'shff00_789a, 32'sh0200_1234, 1'b0, 16'sd0},
        '{32'sh0000_3000, 32'sh0000_9000, 32'sh0000_6000, 1'b0, 16'sd0},
        '{32'sh0000_7000, 32'sh0000_7100, 32'sh0000_2000, 1'b0, 16'sd0},
        '{32'shfffe_8000, 32'sh0001_4000, 32'shffff_c000, 1'b0, 16'sd0},
        '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 1'b0, 16'sd0}
    };

    initial
    begin
        int burst;
        logic signed [COORD_WIDTH-1:0] base_x;
        mismatches = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed points, fixed values where obvious
        foreach (directed[r])
        begin
            send_point(directed[r].x, directed[r].y, directed[r].z);
            if (directed[r].has_value)
                noise_queue[$] = directed[r].value;
        end

        // Random points in bursts, with idle gaps between some of them
        for (int n = 0; n < NUM_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            base_x = random_coord();
            for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_point(base_x + 32'($urandom_range(0, 32'h3ffff)),
                               random_coord(), random_coord());
                else
                    send_point(random_coord(), random_coord(), random_coord());
            end
            // Idle between bursts, or run straight into the next one
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
        end
        start <= 1'b0;

        while (noise_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
